// File: src/i2crw_pkg.sv
// ----------------------------------------------------------------------------
// i2crw_pkg
// Shared types and constants of the I2C register write master.
// ----------------------------------------------------------------------------
package i2crw_pkg;

  // depth of the write buffer and widths that follow from it
  localparam int MAX_BYTES = 16;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int BUF_AW    = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  localparam logic [7:0] TPP_RESET = 8'd2;

  // input actions
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // transaction status codes
  localparam logic [2:0] STAT_OK         = 3'd0;
  localparam logic [2:0] STAT_SDA_LOW    = 3'd1;
  localparam logic [2:0] STAT_SDA_STUCK  = 3'd2;
  localparam logic [2:0] STAT_ADDR_NACK  = 3'd3;
  localparam logic [2:0] STAT_DATA_NACK  = 3'd4;

  // write direction bit appended to the address
  localparam logic DIR_WRITE = 1'b0;

  // one result beat as produced by the engine
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       finished;
    logic [2:0] status;
  } res_t;

endpackage

// File: src/i2crw_if.sv
// ----------------------------------------------------------------------------
// i2crw_if
// Valid/ready channels of the I2C register write master: input and result.
// ----------------------------------------------------------------------------
interface i2crw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic [6:0] target_address;
  logic [7:0] register_index;
  logic [4:0] byte_count;
  logic       sda_sample;

  modport source (
    output valid, action, data_byte, target_address, register_index,
           byte_count, sda_sample,
    input  ready
  );
  modport sink (
    input  valid, action, data_byte, target_address, register_index,
           byte_count, sda_sample,
    output ready
  );
endinterface

interface i2crw_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       busy_res;
  logic       finished;
  logic [2:0] status;

  modport source (
    output valid, scl_level, sda_level, busy_res, finished, status,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, busy_res, finished, status,
    output ready
  );
endinterface

// File: src/i2crw_engine.sv
// ----------------------------------------------------------------------------
// i2crw_engine
// Write buffer and bus sequencer; works out one result beat per accepted tick item.
// ----------------------------------------------------------------------------
module i2crw_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_vld,
  input  logic [1:0]          action,
  input  logic [7:0]          data_byte,
  input  logic [6:0]          target_address,
  input  logic [7:0]          register_index,
  input  logic [4:0]          byte_count,
  input  logic                sda_sample,
  input  logic [7:0]          ticks_per_phase,
  output logic                res_vld,
  output i2crw_pkg::res_t     res
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ADDR,
    S_ADDR_ACK,
    S_REG,
    S_REG_ACK,
    S_DATA,
    S_DATA_ACK,
    S_STOP
  } seq_t;

  seq_t                         seq_r, seq_nxt;
  logic [1:0]                   phase_r, phase_nxt;
  logic [7:0]                   tick_r, tick_nxt;
  logic [2:0]                   bit_r, bit_nxt;
  logic [7:0]                   shift_r, shift_nxt;
  logic [i2crw_pkg::CNT_W-1:0]  pos_r, pos_nxt;
  logic [i2crw_pkg::CNT_W-1:0]  fill_r, fill_nxt;
  logic [6:0]                   addr_r, addr_nxt;
  logic [7:0]                   reg_r, reg_nxt;
  logic [i2crw_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [2:0]                   err_r, err_nxt;
  logic [7:0]                   buf_r [i2crw_pkg::MAX_BYTES];

  logic                         buf_we;
  logic [i2crw_pkg::CNT_W-1:0]  data_pos;
  logic                         has_data;
  logic [7:0]                   rd_byte;
  logic [7:0]                   limit;
  logic [8:0]                   tick_sum;
  logic                         last;
  logic                         busy;
  logic                         ack;
  logic                         scl;
  logic                         sda;
  logic                         fin;

  // next data byte: the ack of a data byte moves on to the following entry
  assign data_pos = (seq_r == S_DATA_ACK) ? pos_r + 1'b1 : pos_r;
  assign has_data = (data_pos < cnt_r);
  assign rd_byte  = buf_r[data_pos[i2crw_pkg::BUF_AW-1:0]];

  assign limit    = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
  assign tick_sum = {1'b0, tick_r} + 9'd1;
  assign last     = (tick_sum >= {1'b0, limit});
  assign busy     = (seq_r != S_IDLE);
  assign ack      = !sda_sample;

  always_comb begin
    seq_nxt   = seq_r;
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    pos_nxt   = pos_r;
    fill_nxt  = fill_r;
    addr_nxt  = addr_r;
    reg_nxt   = reg_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    buf_we    = 1'b0;
    scl       = 1'b1;
    sda       = 1'b1;
    fin       = 1'b0;
    res_vld   = 1'b0;

    if (item_vld && action == i2crw_pkg::ACT_PUSH) begin
      if (seq_r == S_IDLE && fill_r < i2crw_pkg::CNT_W'(i2crw_pkg::MAX_BYTES)) begin
        buf_we   = 1'b1;
        fill_nxt = fill_r + 1'b1;
      end
    end else if (item_vld && action == i2crw_pkg::ACT_START) begin
      if (seq_r == S_IDLE) begin
        addr_nxt = target_address;
        reg_nxt  = register_index;
        if (32'(byte_count) > 32'(i2crw_pkg::MAX_BYTES)) begin
          cnt_nxt = i2crw_pkg::CNT_W'(i2crw_pkg::MAX_BYTES);
        end else begin
          cnt_nxt = i2crw_pkg::CNT_W'(byte_count);
        end
        pos_nxt   = '0;
        fill_nxt  = '0;
        err_nxt   = i2crw_pkg::STAT_OK;
        seq_nxt   = S_START;
        phase_nxt = 2'd0;
        tick_nxt  = 8'd0;
        bit_nxt   = 3'd0;
        shift_nxt = 8'd0;
      end
    end else if (item_vld && action == i2crw_pkg::ACT_TICK) begin
      res_vld = 1'b1;
      if (busy) begin
        tick_nxt = last ? 8'd0 : tick_r + 8'd1;
      end
      case (seq_r)
        S_IDLE: begin
        end
        S_START: begin
          if (phase_r == 2'd0) begin
            scl = 1'b1;
            sda = 1'b1;
            if (last) begin
              if (!sda_sample) begin
                err_nxt = i2crw_pkg::STAT_SDA_LOW;
                fin     = 1'b1;
                seq_nxt = S_IDLE;
              end else begin
                phase_nxt = 2'd1;
              end
            end
          end else if (phase_r == 2'd1) begin
            scl = 1'b1;
            sda = 1'b0;
            if (last) begin
              if (sda_sample) begin
                err_nxt = i2crw_pkg::STAT_SDA_STUCK;
                fin     = 1'b1;
                seq_nxt = S_IDLE;
              end else begin
                phase_nxt = 2'd2;
              end
            end
          end else begin
            scl = 1'b0;
            sda = 1'b0;
            if (last) begin
              seq_nxt   = S_ADDR;
              shift_nxt = {addr_r, i2crw_pkg::DIR_WRITE};
              bit_nxt   = 3'd0;
              phase_nxt = 2'd0;
            end
          end
        end
        S_ADDR, S_REG, S_DATA: begin
          scl = phase_r[0];
          sda = shift_r[7];
          if (last) begin
            if (phase_r == 2'd0) begin
              phase_nxt = 2'd1;
            end else begin
              phase_nxt = 2'd0;
              shift_nxt = {shift_r[6:0], 1'b0};
              if (bit_r == 3'd7) begin
                bit_nxt = 3'd0;
                case (seq_r)
                  S_ADDR:  seq_nxt = S_ADDR_ACK;
                  S_REG:   seq_nxt = S_REG_ACK;
                  default: seq_nxt = S_DATA_ACK;
                endcase
              end else begin
                bit_nxt = bit_r + 3'd1;
              end
            end
          end
        end
        S_ADDR_ACK, S_REG_ACK, S_DATA_ACK: begin
          scl = phase_r[0];
          sda = 1'b1;
          if (last) begin
            if (phase_r == 2'd0) begin
              phase_nxt = 2'd1;
            end else begin
              phase_nxt = 2'd0;
              if (seq_r == S_ADDR_ACK) begin
                if (ack) begin
                  seq_nxt   = S_REG;
                  shift_nxt = reg_r;
                  bit_nxt   = 3'd0;
                end else begin
                  err_nxt = i2crw_pkg::STAT_ADDR_NACK;
                  seq_nxt = S_STOP;
                end
              end else if (seq_r == S_DATA_ACK && !ack) begin
                err_nxt = i2crw_pkg::STAT_DATA_NACK;
                seq_nxt = S_STOP;
              end else begin
                // register ack is ignored; data ack moves to the next entry
                pos_nxt = data_pos;
                if (has_data) begin
                  seq_nxt   = S_DATA;
                  shift_nxt = rd_byte;
                  bit_nxt   = 3'd0;
                end else begin
                  seq_nxt = S_STOP;
                end
              end
            end
          end
        end
        S_STOP: begin
          if (phase_r == 2'd0) begin
            scl = 1'b0;
            sda = 1'b0;
            if (last) phase_nxt = 2'd1;
          end else if (phase_r == 2'd1) begin
            scl = 1'b1;
            sda = 1'b0;
            if (last) phase_nxt = 2'd2;
          end else begin
            scl = 1'b1;
            sda = 1'b1;
            if (last) begin
              fin       = 1'b1;
              seq_nxt   = S_IDLE;
              phase_nxt = 2'd0;
            end
          end
        end
        default: begin
          seq_nxt   = S_IDLE;
          phase_nxt = 2'd0;
          tick_nxt  = 8'd0;
        end
      endcase
    end
  end

  assign res.scl_level = scl;
  assign res.sda_level = sda;
  assign res.busy_res  = busy;
  assign res.finished  = fin;
  assign res.status    = err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= S_IDLE;
      phase_r <= 2'd0;
      tick_r  <= 8'd0;
      bit_r   <= 3'd0;
      shift_r <= 8'd0;
      pos_r   <= '0;
      fill_r  <= '0;
      addr_r  <= 7'd0;
      reg_r   <= 8'd0;
      cnt_r   <= '0;
      err_r   <= i2crw_pkg::STAT_OK;
    end else begin
      seq_r   <= seq_nxt;
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      pos_r   <= pos_nxt;
      fill_r  <= fill_nxt;
      addr_r  <= addr_nxt;
      reg_r   <= reg_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
    end
  end

  // buffer contents survive reset and transactions
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_r[fill_r[i2crw_pkg::BUF_AW-1:0]] <= data_byte;
    end
  end

endmodule

// File: src/i2c_register_write_master_top.sv
// a tick beat's result is registered and shows on the output in the cycle after the beat is taken
// throughput: one input beat per cycle; input stalls only while a result waits
// push and start beats update state and give no result
// reset (rst_n low, synchronous): sequencer idle, counters and status cleared,
// phase length back to 2 ticks; write buffer contents are not cleared
// ----------------------------------------------------------------------------
// i2c_register_write_master_top
// I2C master register write: channel handshake, phase length register and
// output register around the sequencing engine.
// ----------------------------------------------------------------------------
module i2c_register_write_master_top (
  input  logic                clk,
  input  logic                rst_n,
  i2crw_in_if.sink            in_ch,
  i2crw_out_if.source         out_ch,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  logic [7:0]       tpp_r;
  logic             out_vld_r;
  i2crw_pkg::res_t  out_r;
  logic             in_acc;
  logic             res_vld;
  i2crw_pkg::res_t  res;

  // output register frees up in the same cycle it is taken
  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  i2crw_engine u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_vld        (in_acc),
    .action          (in_ch.action),
    .data_byte       (in_ch.data_byte),
    .target_address  (in_ch.target_address),
    .register_index  (in_ch.register_index),
    .byte_count      (in_ch.byte_count),
    .sda_sample      (in_ch.sda_sample),
    .ticks_per_phase (tpp_r),
    .res_vld         (res_vld),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpp_r <= i2crw_pkg::TPP_RESET;
    end else if (cfg_we) begin
      tpp_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_acc && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_vld) begin
      out_r <= res;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.scl_level = out_r.scl_level;
  assign out_ch.sda_level = out_r.sda_level;
  assign out_ch.busy_res  = out_r.busy_res;
  assign out_ch.finished  = out_r.finished;
  assign out_ch.status    = out_r.status;

endmodule

// File: src/i2crw_chk.sv
// ----------------------------------------------------------------------------
// i2crw_chk
// Port-level checks of the I2C register write master, bound to the top level.
// ----------------------------------------------------------------------------
module i2crw_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_level,
  input logic       sda_level,
  input logic       busy_res,
  input logic       finished,
  input logic [2:0] status
);

  // a waiting result beat holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(scl_level) &&
    $stable(sda_level) && $stable(busy_res) && $stable(finished) && $stable(status))
    else $error("result beat changed while stalled");

  // a stalled result blocks the input side
  a_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // no result straight after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with no transaction the bus is released and nothing ends
  a_idle_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy_res |-> scl_level && sda_level && !finished)
    else $error("bus driven while idle");

  // a transaction can only end with a known status
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && finished |-> status <= i2crw_pkg::STAT_DATA_NACK)
    else $error("unknown status code");

endmodule

bind i2c_register_write_master_top i2crw_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .scl_level (out_ch.scl_level),
  .sda_level (out_ch.sda_level),
  .busy_res  (out_ch.busy_res),
  .finished  (out_ch.finished),
  .status    (out_ch.status)
);

// File: tb/i2c_register_write_master_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_write_master_check
// Watches the input, result and phase length ports, predicts the pin levels,
// busy flag and status of every tick beat and compares each result beat with
// the oldest prediction.
// ----------------------------------------------------------------------------
module i2c_register_write_master_check
  import i2crw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  i2crw_in_if         in_ch,
  i2crw_out_if        out_ch,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  output int          pending_ticks,
  output int          error_count
);

  // order matters: each byte state is directly followed by its ack state
  typedef enum logic [3:0] {
    SQ_IDLE, SQ_START, SQ_ADDR, SQ_ADDR_ACK, SQ_REG, SQ_REG_ACK,
    SQ_DATA, SQ_DATA_ACK, SQ_STOP
  } seq_e;

  seq_e       seq;
  logic [1:0] phase;
  logic [7:0] phase_ticks;
  logic [3:0] bit_no;
  logic [7:0] shifter;
  logic [4:0] byte_no;
  logic [4:0] fill;
  logic [7:0] wbuf [MAX_BYTES];
  logic [6:0] addr_q;
  logic [7:0] reg_q;
  logic [4:0] count_q;
  logic [2:0] code;
  logic [7:0] phase_len;
  res_t       levels_q [$];
  int         fails = 0;

  function automatic void load_shift(input seq_e nxt, input logic [7:0] value);
    seq     = nxt;
    shifter = value;
    bit_no  = '0;
    phase   = '0;
  endfunction

  function automatic void data_or_stop();
    if (byte_no < count_q && byte_no < MAX_BYTES) begin
      load_shift(SQ_DATA, wbuf[byte_no[3:0]]);
    end else begin
      seq   = SQ_STOP;
      phase = '0;
    end
  endfunction

  function automatic res_t tick_levels(input logic sda_in);
    res_t r;
    int   limit;
    logic last;
    r.scl_level = 1'b1;
    r.sda_level = 1'b1;
    r.busy_res  = (seq != SQ_IDLE);
    r.finished  = 1'b0;
    limit = (phase_len == 8'd0) ? 1 : int'(phase_len);
    last  = (int'(phase_ticks) + 1 >= limit);
    if (seq != SQ_IDLE) phase_ticks = last ? 8'd0 : phase_ticks + 8'd1;

    case (seq)
      SQ_START: begin
        if (phase == 2'd0) begin
          if (last) begin
            if (!sda_in) begin
              code = STAT_SDA_LOW;
              r.finished = 1'b1;
              seq = SQ_IDLE;
            end else begin
              phase = 2'd1;
            end
          end
        end else if (phase == 2'd1) begin
          r.sda_level = 1'b0;
          if (last) begin
            if (sda_in) begin
              code = STAT_SDA_STUCK;
              r.finished = 1'b1;
              seq = SQ_IDLE;
            end else begin
              phase = 2'd2;
            end
          end
        end else begin
          r.scl_level = 1'b0;
          r.sda_level = 1'b0;
          if (last) load_shift(SQ_ADDR, {addr_q, DIR_WRITE});
        end
      end
      SQ_ADDR, SQ_REG, SQ_DATA: begin
        r.scl_level = (phase != 2'd0);
        r.sda_level = shifter[7];
        if (last) begin
          if (phase == 2'd0) begin
            phase = 2'd1;
          end else begin
            phase   = 2'd0;
            shifter = shifter << 1;
            bit_no  = bit_no + 4'd1;
            if (bit_no >= 4'd8) begin
              bit_no = '0;
              seq    = seq_e'(seq + 4'd1);
            end
          end
        end
      end
      SQ_ADDR_ACK, SQ_REG_ACK, SQ_DATA_ACK: begin
        r.scl_level = (phase != 2'd0);
        if (last) begin
          if (phase == 2'd0) begin
            phase = 2'd1;
          end else begin
            phase = 2'd0;
            case (seq)
              SQ_ADDR_ACK: begin
                if (!sda_in) begin
                  load_shift(SQ_REG, reg_q);
                end else begin
                  code = STAT_ADDR_NACK;
                  seq  = SQ_STOP;
                end
              end
              // register ack is clocked but never looked at
              SQ_REG_ACK: data_or_stop();
              default: begin
                if (!sda_in) begin
                  byte_no = byte_no + 5'd1;
                  data_or_stop();
                end else begin
                  code = STAT_DATA_NACK;
                  seq  = SQ_STOP;
                end
              end
            endcase
          end
        end
      end
      SQ_STOP: begin
        if (phase == 2'd0) begin
          r.scl_level = 1'b0;
          r.sda_level = 1'b0;
          if (last) phase = 2'd1;
        end else if (phase == 2'd1) begin
          r.sda_level = 1'b0;
          if (last) phase = 2'd2;
        end else if (last) begin
          r.finished = 1'b1;
          seq   = SQ_IDLE;
          phase = 2'd0;
        end
      end
      default: ;
    endcase
    r.status = code;
    return r;
  endfunction

  function automatic void take_beat();
    case (in_ch.action)
      ACT_PUSH: begin
        if (seq == SQ_IDLE && fill < MAX_BYTES) begin
          wbuf[fill[3:0]] = in_ch.data_byte;
          fill = fill + 5'd1;
        end
      end
      ACT_START: begin
        if (seq == SQ_IDLE) begin
          addr_q  = in_ch.target_address;
          reg_q   = in_ch.register_index;
          count_q = (in_ch.byte_count > MAX_BYTES) ? 5'(MAX_BYTES) : in_ch.byte_count;
          byte_no = '0;
          fill    = '0;
          code    = STAT_OK;
          seq     = SQ_START;
          phase   = '0;
          phase_ticks = '0;
          bit_no  = '0;
          shifter = '0;
        end
      end
      ACT_TICK: levels_q.push_back(tick_levels(in_ch.sda_sample));
      default: ;
    endcase
  endfunction

  function automatic int field_diff(input string name, input logic [2:0] want,
                                    input logic [2:0] got);
    if (got === want) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      seq         = SQ_IDLE;
      phase       = '0;
      phase_ticks = '0;
      bit_no      = '0;
      shifter     = '0;
      byte_no     = '0;
      fill        = '0;
      addr_q      = '0;
      reg_q       = '0;
      count_q     = '0;
      code        = STAT_OK;
      phase_len   = TPP_RESET;
      levels_q.delete();
    end else begin
      // a beat taken at the same edge as a write still sees the old length
      if (in_ch.valid && in_ch.ready) take_beat();
      if (cfg_we) phase_len = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        got.scl_level = out_ch.scl_level;
        got.sda_level = out_ch.sda_level;
        got.busy_res  = out_ch.busy_res;
        got.finished  = out_ch.finished;
        got.status    = out_ch.status;
        if (levels_q.size() == 0) begin
          $error("result beat with no tick beat waiting for it");
          fails++;
        end else begin
          want = levels_q.pop_front();
          fails += field_diff("scl_level", want.scl_level, got.scl_level);
          fails += field_diff("sda_level", want.sda_level, got.sda_level);
          fails += field_diff("busy_res", want.busy_res, got.busy_res);
          fails += field_diff("finished", want.finished, got.finished);
          fails += field_diff("status", want.status, got.status);
        end
      end
    end
    pending_ticks <= levels_q.size();
    error_count   <= fails;
  end

endmodule

// File: tb/i2c_register_write_master_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_write_master_top_test
// Runs whole write transactions on the register write master: buffered data,
// start, and tick beats whose SDA samples acknowledge, refuse or break the
// sequence, at several phase lengths and under random back pressure. The
// checker beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module i2c_register_write_master_top_test;
  import i2crw_pkg::*;

  localparam int ITEM_GOAL     = 1650;
  // closing slow transfers, with room for the last transfer of a stage running over
  localparam int TAIL_ITEMS    = 900;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;

  // spare action code, the block takes the beat and does nothing
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef enum int {
    FAULT_NONE, FAULT_SDA_LOW, FAULT_SDA_STUCK, FAULT_ADDR_NACK, FAULT_DATA_NACK
  } fault_e;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;
  int         pending_ticks;
  int         error_count;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         hold_left = 0;
  int         cycle_no = 0;
  int         sent_items = 0;
  int         phase_len = 2;
  int         fill_now = 0;
  int         written_hi = 0;

  i2crw_in_if  in_bus ();
  i2crw_out_if out_bus ();

  i2c_register_write_master_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  i2c_register_write_master_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_bus),
    .out_ch        (out_bus),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .pending_ticks (pending_ticks),
    .error_count   (error_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off counted down here
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_beat(input logic [1:0] act, input logic [7:0] data,
                           input logic [6:0] addr, input logic [7:0] regi,
                           input logic [4:0] cnt, input logic sda);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.action         <= act;
    in_bus.data_byte      <= data;
    in_bus.target_address <= addr;
    in_bus.register_index <= regi;
    in_bus.byte_count     <= cnt;
    in_bus.sda_sample     <= sda;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic bus_tick(input logic sda);
    send_beat(ACT_TICK, 8'($urandom), 7'($urandom), 8'($urandom), 5'($urandom), sda);
    sent_items++;
  endtask

  // only called while the sequencer is idle
  task automatic push_beat(input logic [7:0] data);
    send_beat(ACT_PUSH, data, 7'($urandom), 8'($urandom), 5'($urandom), 1'($urandom));
    if (fill_now < MAX_BYTES) begin
      fill_now++;
      if (fill_now > written_hi) written_hi = fill_now;
    end
    sent_items++;
  endtask

  task automatic start_beat(input logic [4:0] cnt);
    send_beat(ACT_START, 8'($urandom), 7'($urandom), 8'($urandom), cnt, 1'($urandom));
    fill_now = 0;
    sent_items++;
  endtask

  // beats the block drops while a transaction runs
  task automatic busy_noise();
    logic [1:0] act;
    case ($urandom_range(2))
      0: act = ACT_PUSH;
      1: act = ACT_START;
      default: act = ACT_SPARE;
    endcase
    send_beat(act, 8'($urandom), 7'($urandom), 8'($urandom), 5'($urandom), 1'($urandom));
    sent_items++;
  endtask

  // one bus phase; the line level only matters on its last tick when sampled
  task automatic run_phase(input bit sampled, input logic level);
    for (int i = 0; i < phase_len; i++) begin
      if ($urandom_range(15) == 0) busy_noise();
      bus_tick((sampled && i == phase_len - 1) ? level : logic'($urandom_range(1)));
    end
  endtask

  task automatic run_transfer(input logic [4:0] n_req, input fault_e fault,
                              input int nack_at);
    int n_sent;
    n_sent = (n_req > MAX_BYTES) ? MAX_BYTES : int'(n_req);
    start_beat(n_req);
    run_phase(1'b1, fault != FAULT_SDA_LOW);
    if (fault == FAULT_SDA_LOW) return;
    run_phase(1'b1, fault == FAULT_SDA_STUCK);
    if (fault == FAULT_SDA_STUCK) return;
    run_phase(1'b0, 1'b0);
    // address with write bit, then its ack
    repeat (17) run_phase(1'b0, 1'b0);
    run_phase(1'b1, fault == FAULT_ADDR_NACK);
    if (fault != FAULT_ADDR_NACK) begin
      // register byte and an ack that nobody checks
      repeat (18) run_phase(1'b0, 1'b0);
      for (int k = 0; k < n_sent; k++) begin
        repeat (17) run_phase(1'b0, 1'b0);
        run_phase(1'b1, fault == FAULT_DATA_NACK && k == nack_at);
        if (fault == FAULT_DATA_NACK && k == nack_at) break;
      end
    end
    repeat (3) run_phase(1'b0, 1'b0);
  endtask

  task automatic random_transfer();
    int     n_push;
    int     roll;
    int     n_req;
    fault_e fault;
    n_push = ($urandom_range(7) == 0) ? int'($urandom_range(MAX_BYTES + 3))
                                      : int'($urandom_range(4));
    repeat (n_push) push_beat(8'($urandom));
    if ($urandom_range(3) == 0) bus_tick(1'($urandom_range(1)));
    // mostly the bytes just pushed; now and then stale entries or a count past the buffer
    roll = int'($urandom_range(9));
    if (roll < 7) n_req = fill_now;
    else if (roll == 9 && written_hi == MAX_BYTES) n_req = int'($urandom_range(31));
    else n_req = int'($urandom_range(written_hi));
    case ($urandom_range(15))
      0: fault = FAULT_SDA_LOW;
      1: fault = FAULT_SDA_STUCK;
      2: fault = FAULT_ADDR_NACK;
      3: fault = FAULT_DATA_NACK;
      default: fault = FAULT_NONE;
    endcase
    run_transfer(5'(n_req), fault, int'($urandom_range((n_req > 0) ? n_req - 1 : 0)));
    repeat ($urandom_range(2)) bus_tick(1'($urandom_range(1)));
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending_ticks != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_phase_len(input logic [7:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    phase_len = (value == 8'd0) ? 1 : int'(value);
  endtask

  initial begin
    in_bus.valid          = 1'b0;
    in_bus.action         = ACT_TICK;
    in_bus.data_byte      = 8'd0;
    in_bus.target_address = 7'd0;
    in_bus.register_index = 8'd0;
    in_bus.byte_count     = 5'd0;
    in_bus.sda_sample     = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short directed run at the reset phase length
    push_beat(8'h00);
    push_beat(8'hFF);
    bus_tick(1'b0);
    bus_tick(1'b1);
    send_beat(ACT_SPARE, 8'hFF, 7'h7F, 8'hFF, 5'h1F, 1'b1);
    set_phase_len(8'd1);
    run_transfer(5'd0, FAULT_SDA_LOW, 0);
    run_transfer(5'd0, FAULT_SDA_STUCK, 0);
    // phase length cut below the ticks already spent in the first start phase
    set_phase_len(8'd5);
    start_beat(5'd0);
    repeat (3) bus_tick(1'b1);
    set_phase_len(8'd2);
    bus_tick(1'b0);

    for (int stage = 0; stage < 4; stage++) begin
      case (stage)
        0: begin
          set_phase_len(8'd1);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_left      = HOLD_CYCLES;
        end
        1: begin
          set_phase_len(8'd0);
          send_idle_pct  = 60;
          recv_stall_pct = 0;
        end
        2: begin
          set_phase_len(8'd3);
          send_idle_pct  = 0;
          recv_stall_pct = 60;
        end
        default: begin
          set_phase_len(8'd2);
          send_idle_pct  = 32;
          recv_stall_pct = 32;
        end
      endcase
      while (sent_items < (ITEM_GOAL - TAIL_ITEMS) * (stage + 1) / 4) random_transfer();
    end

    // longest phase: only the start condition, it is slow enough as it is
    set_phase_len(8'd255);
    run_transfer(5'($urandom), FAULT_SDA_LOW, 0);
    run_transfer(5'($urandom), FAULT_SDA_STUCK, 0);

    drain();
    repeat (8) @(negedge clk);
    if (error_count == 0 && pending_ticks == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
